### hdl/dprlp_pkg.sv
// Shared types and constants for the run-list planner.
package dprlp_pkg;

  localparam logic [1:0] REQ_CREATE  = 2'd0;
  localparam logic [1:0] REQ_SET_PRI = 2'd1;
  localparam logic [1:0] REQ_SET_RUN = 2'd2;
  localparam logic [1:0] REQ_PLAN    = 2'd3;

  localparam logic [1:0] RS_RUN     = 2'd0;
  localparam logic [1:0] RS_BLOCKED = 2'd1;
  localparam logic [1:0] RS_FREE    = 2'd2;

  localparam logic [1:0] CFG_IDLE_SLOT   = 2'd0;
  localparam logic [1:0] CFG_BONUS_LIMIT = 2'd1;
  localparam logic [1:0] CFG_DEF_PRI     = 2'd2;

  localparam logic [31:0] IDLE_PRI    = 32'hFFFF_FFFF;
  localparam logic [3:0]  IDLE_SLOT_RST = 4'd1;
  localparam logic [7:0]  BONUS_LIMIT_RST = 8'd128;
  localparam logic [31:0] DEF_PRI_RST = 32'd10;
  localparam int          MAX_OUT     = 16;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  slot;
    logic [31:0] priority_req;
    logic [1:0]  run_state;
  } in_t;

  typedef struct packed {
    logic [3:0] run_slot;
    logic       last;
    logic       none_runnable;
    logic       bad_priority;
  } out_t;

  typedef struct packed {
    logic plan_init;
    logic step_init;
    logic p1;
    logic p2;
    logic pick;
    logic commit;
    logic emit;
    logic none;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic run_any;
    logic commit_ok;
    logic cnt_zero;
    logic cnt_last;
    logic emit_last;
    logic out_free;
  } sts_t;

endpackage

### hdl/dynamic_priority_run_list_planner_unit.sv
// Run-list planner top level: slot table requests and plan requests.
// A table request (create, set priority, set run state) gives no result.
// A plan request runs up to 16 selection steps; each step walks the slot
// table with a single index, one slot a cycle, once for the lowest dynamic
// priority and, if any slot is runnable, again to rebase and find a candidate,
// then goes through pick and commit. The chain buffer is then emitted one item
// per cycle while the output is not stalled. Inputs are taken only between plans.
module dynamic_priority_run_list_planner_unit #(
  parameter int SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dprlp_pkg::in_t    in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output dprlp_pkg::out_t   out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_wdata
);

  dprlp_pkg::cmd_t cmd;
  dprlp_pkg::sts_t sts;

  dprlp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dprlp_dp #(.SLOTS(SLOTS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### hdl/dprlp_ctrl.sv
// Sequencer for plan requests: walk passes, pick, commit and emission.
module dprlp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  dprlp_pkg::in_t     in_data,
  output logic               in_stall,
  input  dprlp_pkg::sts_t    sts,
  output dprlp_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_P1     = 3'd1;
  localparam logic [2:0] S_P2     = 3'd2;
  localparam logic [2:0] S_PICK   = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;
  localparam logic [2:0] S_NONE   = 3'd6;

  logic [2:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_data.req_type == dprlp_pkg::REQ_PLAN) begin
          cmd.plan_init = 1'b1;
          cmd.step_init = 1'b1;
          state_nxt = S_P1;
        end
      end
      S_P1: begin
        cmd.p1 = 1'b1;
        if (sts.idx_last) state_nxt = S_P2;
      end
      S_P2: begin
        // a pass with nothing runnable ends the plan here
        if (!sts.run_any) begin
          state_nxt = sts.cnt_zero ? S_NONE : S_EMIT;
        end else begin
          cmd.p2 = 1'b1;
          if (sts.idx_last) state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        cmd.pick = 1'b1;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        priority if (!sts.commit_ok) begin
          state_nxt = sts.cnt_zero ? S_IDLE : S_EMIT;
        end else if (sts.cnt_last) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.step_init = 1'b1;
          state_nxt = S_P1;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.emit_last) state_nxt = S_IDLE;
        end
      end
      S_NONE: begin
        if (sts.out_free) begin
          cmd.none = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

`ifndef SYNTHESIS
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_P2) |-> in_stall)
    else $error("input taken during a plan");
  a_pick_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pick |=> cmd.commit)
    else $error("pick not followed by commit");
  a_step_p1: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step_init |=> (state_r == S_P1))
    else $error("step start lost");
`endif

endmodule

### hdl/dprlp_dp.sv
// Slot table, selection datapath, chain buffer and output register.
module dprlp_dp #(
  parameter int SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  dprlp_pkg::in_t     in_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  dprlp_pkg::cmd_t    cmd,
  output dprlp_pkg::sts_t    sts,
  output logic               out_valid,
  input  logic               out_stall,
  output dprlp_pkg::out_t    out_data
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [1:0]  st_r  [SLOTS];
  logic [31:0] pri_r [SLOTS];
  logic [31:0] dyn_r [SLOTS];
  logic [7:0]  bon_r [SLOTS];
  logic [SLOTS-1:0] mark_r;

  logic [3:0]  idle_slot_r;
  logic [7:0]  bonus_limit_r;
  logic [31:0] def_pri_r;

  logic [IW-1:0] idx_r;
  logic [31:0]   min_r;
  logic          run_any_r, bad_r, found_r, callv_r, chv_r;
  logic [IW-1:0] cand_r, ch_r;
  logic [3:0]    caller_r;
  logic [4:0]    cnt_r;
  logic [3:0]    eidx_r;
  logic [3:0]    chain_r [dprlp_pkg::MAX_OUT];
  logic          out_valid_r;
  dprlp_pkg::out_t out_r;

  logic          idx_last, is_caller, commit_ok, tbl_wr;
  logic [31:0]   dv, d2;
  logic [IW-1:0] pick_idx;
  logic [7:0]    cb, cb2;
  logic [32:0]   sum;

  assign idx_last  = (32'(idx_r) == 32'(SLOTS - 1));
  assign is_caller = (32'(idx_r) == 32'(caller_r));
  assign dv = (pri_r[idx_r] == dprlp_pkg::IDLE_PRI) ? dprlp_pkg::IDLE_PRI : dyn_r[idx_r];
  assign d2 = (dyn_r[idx_r] != 32'd0) ? dyn_r[idx_r] - min_r : 32'd0;
  assign pick_idx = found_r ? cand_r : IW'(caller_r);
  assign cb  = bon_r[ch_r];
  assign cb2 = (cb < bonus_limit_r) ? cb + 8'd1 : cb;
  assign sum = {1'b0, pri_r[ch_r]} + {25'd0, cb2};
  assign commit_ok = chv_r && !mark_r[ch_r] &&
                     !((cnt_r != 5'd0) && (32'(ch_r) == 32'(idle_slot_r)));
  assign tbl_wr = in_valid && !in_stall && (in_data.req_type != dprlp_pkg::REQ_PLAN) &&
                  (32'(in_data.slot) < 32'(SLOTS));

  always_comb begin
    sts.idx_last  = idx_last;
    sts.run_any   = run_any_r;
    sts.commit_ok = commit_ok;
    sts.cnt_zero  = (cnt_r == 5'd0);
    sts.cnt_last  = (cnt_r == 5'(dprlp_pkg::MAX_OUT - 1));
    sts.emit_last = (5'(eidx_r) + 5'd1 == cnt_r);
    sts.out_free  = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_slot_r   <= dprlp_pkg::IDLE_SLOT_RST;
      bonus_limit_r <= dprlp_pkg::BONUS_LIMIT_RST;
      def_pri_r     <= dprlp_pkg::DEF_PRI_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dprlp_pkg::CFG_IDLE_SLOT:   idle_slot_r   <= cfg_wdata[3:0];
        dprlp_pkg::CFG_BONUS_LIMIT: bonus_limit_r <= cfg_wdata[7:0];
        dprlp_pkg::CFG_DEF_PRI:     def_pri_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // slot table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        st_r[i]  <= dprlp_pkg::RS_FREE;
        pri_r[i] <= '0;
        dyn_r[i] <= '0;
        bon_r[i] <= '0;
      end
      mark_r <= '0;
    end else begin
      if (tbl_wr) begin
        unique case (in_data.req_type)
          dprlp_pkg::REQ_CREATE: begin
            st_r[IW'(in_data.slot)]   <= dprlp_pkg::RS_RUN;
            pri_r[IW'(in_data.slot)]  <= def_pri_r;
            dyn_r[IW'(in_data.slot)]  <= '0;
            bon_r[IW'(in_data.slot)]  <= '0;
            mark_r[IW'(in_data.slot)] <= 1'b0;
          end
          dprlp_pkg::REQ_SET_PRI: pri_r[IW'(in_data.slot)] <= in_data.priority_req;
          dprlp_pkg::REQ_SET_RUN: begin
            if (in_data.run_state <= dprlp_pkg::RS_FREE) begin
              st_r[IW'(in_data.slot)] <= in_data.run_state;
            end
          end
          default: ;
        endcase
      end
      if (cmd.plan_init) mark_r <= '0;
      if (cmd.p1 && st_r[idx_r] != dprlp_pkg::RS_FREE &&
          pri_r[idx_r] == dprlp_pkg::IDLE_PRI) begin
        dyn_r[idx_r] <= dprlp_pkg::IDLE_PRI;
      end
      if (cmd.p2 && st_r[idx_r] != dprlp_pkg::RS_FREE) begin
        if (st_r[idx_r] == dprlp_pkg::RS_RUN) dyn_r[idx_r] <= d2;
        // candidates keep their bonus, all other non-free slots decay
        if (!(st_r[idx_r] == dprlp_pkg::RS_RUN && !is_caller && d2 == 32'd0) &&
            bon_r[idx_r] != 8'd0) begin
          bon_r[idx_r] <= bon_r[idx_r] - 8'd1;
        end
      end
      if (cmd.pick && (found_r || callv_r) && bon_r[pick_idx] < bonus_limit_r) begin
        bon_r[pick_idx] <= bon_r[pick_idx] + 8'd1;
      end
      if (cmd.commit && commit_ok) begin
        bon_r[ch_r]  <= cb2;
        dyn_r[ch_r]  <= sum[32] ? dprlp_pkg::IDLE_PRI : sum[31:0];
        mark_r[ch_r] <= 1'b1;
      end
    end
  end

  // walk and step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      cnt_r <= '0;
      eidx_r <= '0;
      run_any_r <= 1'b0;
      bad_r <= 1'b0;
      found_r <= 1'b0;
      callv_r <= 1'b0;
      chv_r <= 1'b0;
    end else begin
      if (cmd.p1 || cmd.p2) idx_r <= idx_last ? '0 : idx_r + IW'(1);
      if (cmd.plan_init) begin
        idx_r    <= '0;
        cnt_r    <= '0;
        eidx_r   <= '0;
        bad_r    <= 1'b0;
        caller_r <= in_data.slot;
        callv_r  <= (32'(in_data.slot) < 32'(SLOTS));
      end
      if (cmd.step_init) begin
        min_r     <= dprlp_pkg::IDLE_PRI;
        run_any_r <= 1'b0;
        found_r   <= 1'b0;
      end
      if (cmd.p1 && st_r[idx_r] == dprlp_pkg::RS_RUN) begin
        run_any_r <= 1'b1;
        if (pri_r[idx_r] == 32'd0) bad_r <= 1'b1;
        if (dv < min_r) min_r <= dv;
      end
      if (cmd.p2 && st_r[idx_r] == dprlp_pkg::RS_RUN && !is_caller && d2 == 32'd0) begin
        found_r <= 1'b1;
        cand_r  <= idx_r;
      end
      if (cmd.pick) begin
        ch_r  <= pick_idx;
        chv_r <= found_r || callv_r;
      end
      if (cmd.commit && commit_ok) begin
        chain_r[cnt_r[3:0]] <= 4'(ch_r);
        cnt_r <= cnt_r + 5'd1;
      end
      if (cmd.emit) eidx_r <= eidx_r + 4'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid_r         <= 1'b1;
        out_r.run_slot      <= chain_r[eidx_r];
        out_r.last          <= (5'(eidx_r) + 5'd1 == cnt_r);
        out_r.none_runnable <= 1'b0;
        out_r.bad_priority  <= bad_r;
      end else if (cmd.none) begin
        out_valid_r         <= 1'b1;
        out_r.run_slot      <= '0;
        out_r.last          <= 1'b1;
        out_r.none_runnable <= 1'b1;
        out_r.bad_priority  <= 1'b0;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 5'(dprlp_pkg::MAX_OUT))
    else $error("chain count overflow");
  a_commit_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && commit_ok) |=> (cnt_r == $past(cnt_r) + 5'd1))
    else $error("commit did not extend chain");
  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.none |=> (out_valid_r && out_r.last && out_r.none_runnable))
    else $error("empty plan result malformed");
`endif

endmodule

### dv/dynamic_priority_run_list_planner_unit_tb.sv
// Testbench for the run-list planner: table edits, plan chains and configuration writes.
`timescale 1ns / 1ps

module dynamic_priority_run_list_planner_unit_tb;

  localparam int NSLOT = 16;
  // wait bound for one plan of 16 selection steps, plus drain
  localparam int PLAN_CYCLES = 16 * (2 * NSLOT + 2) + 40;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  dprlp_pkg::in_t  in_data;
  logic        out_valid;
  logic        out_stall;
  dprlp_pkg::out_t out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  dynamic_priority_run_list_planner_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // planner model state
  logic [3:0]  m_idle_slot;
  logic [7:0]  m_bonus_limit;
  logic [31:0] m_def_pri;
  logic [1:0]  m_state [NSLOT];
  logic [31:0] m_pri   [NSLOT];
  logic [31:0] m_dyn   [NSLOT];
  logic [7:0]  m_bonus [NSLOT];
  logic        m_mark  [NSLOT];

  dprlp_pkg::out_t chain_q[$];
  int   n_errors;
  bit   hold_off;
  int   hold_cycles;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void model_reset();
    m_idle_slot = dprlp_pkg::IDLE_SLOT_RST;
    m_bonus_limit = dprlp_pkg::BONUS_LIMIT_RST;
    m_def_pri = dprlp_pkg::DEF_PRI_RST;
    for (int i = 0; i < NSLOT; i++) begin
      m_state[i] = dprlp_pkg::RS_FREE;
      m_pri[i] = '0;
      m_dyn[i] = '0;
      m_bonus[i] = '0;
      m_mark[i] = 1'b0;
    end
  endfunction

  // append one expected result
  function automatic void expect_result(input dprlp_pkg::out_t r);
    chain_q = {chain_q, r};
  endfunction

  // one selection step; returns 0 when nothing is runnable
  function automatic bit select_pick(input int caller, output int pick, inout bit bad);
    logic [31:0] lowest;
    int nrun;
    bit found;
    lowest = dprlp_pkg::IDLE_PRI;
    nrun = 0;
    found = 0;
    pick = caller;
    for (int i = 0; i < NSLOT; i++) begin
      if (m_state[i] == dprlp_pkg::RS_FREE) continue;
      if (m_pri[i] == dprlp_pkg::IDLE_PRI) m_dyn[i] = dprlp_pkg::IDLE_PRI;
      if (m_state[i] == dprlp_pkg::RS_RUN) begin
        if (m_pri[i] == 0) bad = 1;
        nrun++;
        if (m_dyn[i] < lowest) lowest = m_dyn[i];
      end
    end
    if (nrun == 0) return 0;
    for (int i = 0; i < NSLOT; i++) begin
      if (m_state[i] == dprlp_pkg::RS_FREE) continue;
      if (m_state[i] == dprlp_pkg::RS_RUN) begin
        if (m_dyn[i] != 0) m_dyn[i] -= lowest;
        if (i != caller && m_dyn[i] == 0) begin
          found = 1;
          pick = i;
          continue;
        end
      end
      if (m_bonus[i] != 0) m_bonus[i]--;
    end
    if (!found) pick = caller;
    if (m_bonus[pick] < m_bonus_limit) m_bonus[pick]++;
    return 1;
  endfunction

  function automatic void predict_item(input dprlp_pkg::in_t it);
    int chain[$];
    int pick;
    bit bad;
    logic [32:0] sum;
    dprlp_pkg::out_t r;
    bad = 0;
    if (it.req_type != dprlp_pkg::REQ_PLAN) begin
      case (it.req_type)
        dprlp_pkg::REQ_CREATE: begin
          m_state[it.slot] = dprlp_pkg::RS_RUN;
          m_pri[it.slot] = m_def_pri;
          m_dyn[it.slot] = '0;
          m_bonus[it.slot] = '0;
          m_mark[it.slot] = 1'b0;
        end
        dprlp_pkg::REQ_SET_PRI: m_pri[it.slot] = it.priority_req;
        default: begin
          if (it.run_state <= dprlp_pkg::RS_FREE) m_state[it.slot] = it.run_state;
        end
      endcase
      return;
    end
    for (int i = 0; i < NSLOT; i++) m_mark[i] = 1'b0;
    while (chain.size() < dprlp_pkg::MAX_OUT) begin
      if (!select_pick(int'(it.slot), pick, bad)) begin
        if (chain.size() == 0) begin
          r = '{run_slot: 4'd0, last: 1'b1, none_runnable: 1'b1, bad_priority: 1'b0};
          expect_result(r);
          return;
        end
        break;
      end
      if (m_mark[pick] || (chain.size() != 0 && pick == m_idle_slot)) break;
      if (m_bonus[pick] < m_bonus_limit) m_bonus[pick]++;
      sum = {1'b0, m_pri[pick]} + {25'd0, m_bonus[pick]};
      m_dyn[pick] = sum[32] ? dprlp_pkg::IDLE_PRI : sum[31:0];
      m_mark[pick] = 1'b1;
      chain = {chain, pick};
    end
    foreach (chain[i]) begin
      r.run_slot = chain[i][3:0];
      r.last = (i == chain.size() - 1);
      r.none_runnable = 1'b0;
      r.bad_priority = bad;
      expect_result(r);
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    dprlp_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (chain_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result %p", out_data);
      end else begin
        want = chain_q.pop_front();
        if (out_data.run_slot !== want.run_slot || out_data.last !== want.last ||
            out_data.none_runnable !== want.none_runnable ||
            out_data.bad_priority !== want.bad_priority) begin
          n_errors++;
          if (n_errors <= 10) $display("mismatch: expected %p got %p", want, out_data);
        end
      end
    end
  end

  // receiver stall
  initial begin
    int g;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_off = 0;
      end
      g = gap_len();
      out_stall <= (g != 0);
      repeat (g > 0 ? g : $urandom_range(1, 6)) @(posedge clk);
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  // valid stays high after the accepting edge; the next item or drain drops it
  task automatic send_item(input dprlp_pkg::in_t it, input bit no_gap = 0);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    predict_item(it);
  endtask

  task automatic table_op(input logic [1:0] rq, input int s,
                          input logic [31:0] p = 0, input logic [1:0] rs = 0);
    dprlp_pkg::in_t it;
    it.req_type = rq;
    it.slot = 4'(s);
    it.priority_req = p;
    it.run_state = rs;
    send_item(it);
  endtask

  task automatic drain();
    int n;
    n = 0;
    in_valid <= 1'b0;
    while (chain_q.size() != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (PLAN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [31:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      dprlp_pkg::CFG_IDLE_SLOT:   m_idle_slot = val[3:0];
      dprlp_pkg::CFG_BONUS_LIMIT: m_bonus_limit = val[7:0];
      dprlp_pkg::CFG_DEF_PRI:     m_def_pri = val;
      default: ;
    endcase
  endtask

  task automatic test_directed();
    table_op(dprlp_pkg::REQ_PLAN, 0);                            // nothing runnable
    table_op(dprlp_pkg::REQ_CREATE, 0);
    table_op(dprlp_pkg::REQ_CREATE, 15);
    table_op(dprlp_pkg::REQ_CREATE, 1);
    table_op(dprlp_pkg::REQ_SET_PRI, 1, dprlp_pkg::IDLE_PRI);    // idle thread
    table_op(dprlp_pkg::REQ_PLAN, 0);
    table_op(dprlp_pkg::REQ_SET_PRI, 15, 32'hFFFF_FFFE);         // overflow of priority+bonus
    table_op(dprlp_pkg::REQ_PLAN, 15);
    table_op(dprlp_pkg::REQ_SET_PRI, 0, 32'd0);                  // priority zero
    table_op(dprlp_pkg::REQ_PLAN, 0);
    table_op(dprlp_pkg::REQ_SET_RUN, 0, 0, 2'd3);                // ignored run state
    table_op(dprlp_pkg::REQ_SET_RUN, 15, 0, dprlp_pkg::RS_BLOCKED);
    table_op(dprlp_pkg::REQ_PLAN, 15);                           // blocked caller as fallback
    table_op(dprlp_pkg::REQ_CREATE, 15);                         // reinit used slot
    table_op(dprlp_pkg::REQ_SET_RUN, 0, 0, dprlp_pkg::RS_FREE);
    table_op(dprlp_pkg::REQ_PLAN, 7);                            // free caller
    for (int i = 2; i < 8; i++) table_op(dprlp_pkg::REQ_CREATE, i);
    table_op(dprlp_pkg::REQ_PLAN, 3);
  endtask

  task automatic test_random(input int n);
    dprlp_pkg::in_t it;
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      it.slot = 4'($urandom_range(0, 15));
      it.priority_req = $urandom();
      it.run_state = 2'($urandom_range(0, 3));
      if (r < 20) it.req_type = dprlp_pkg::REQ_CREATE;
      else if (r < 40) begin
        it.req_type = dprlp_pkg::REQ_SET_PRI;
        case ($urandom_range(0, 5))
          0: it.priority_req = dprlp_pkg::IDLE_PRI;
          1: it.priority_req = 0;
          2, 3: it.priority_req = $urandom_range(1, 40);
          default: ;
        endcase
      end else if (r < 60) begin
        it.req_type = dprlp_pkg::REQ_SET_RUN;
        if ($urandom_range(0, 3) != 0) it.run_state = 2'($urandom_range(0, 1));
      end else it.req_type = dprlp_pkg::REQ_PLAN;
      send_item(it);
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 3000;
    hold_off = 1;
    for (int k = 0; k < 8; k++) begin
      dprlp_pkg::in_t it;
      it = '{req_type: dprlp_pkg::REQ_PLAN, slot: 4'($urandom_range(0, 15)),
             priority_req: 32'd0, run_state: dprlp_pkg::RS_RUN};
      send_item(it, 1);
    end
    drain();
    test_random(20);
  endtask

  initial begin
    n_errors = 0;
    hold_off = 0;
    hold_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = dprlp_pkg::CFG_IDLE_SLOT;
    cfg_wdata = '0;
    model_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(80);
    test_backpressure();
    write_cfg(dprlp_pkg::CFG_IDLE_SLOT, 32'd15);
    write_cfg(dprlp_pkg::CFG_BONUS_LIMIT, 32'd0);
    write_cfg(dprlp_pkg::CFG_DEF_PRI, 32'hFFFF_FFFF);
    test_random(60);
    write_cfg(dprlp_pkg::CFG_IDLE_SLOT, 32'd0);
    write_cfg(dprlp_pkg::CFG_BONUS_LIMIT, 32'd255);
    write_cfg(dprlp_pkg::CFG_DEF_PRI, 32'd1);
    test_random(80);
    write_cfg(dprlp_pkg::CFG_IDLE_SLOT, 32'd6);
    write_cfg(dprlp_pkg::CFG_BONUS_LIMIT, 32'd3);
    write_cfg(dprlp_pkg::CFG_DEF_PRI, 32'd5);
    test_random(60);

    drain();
    if (n_errors == 0 && chain_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
